// ===== design/tlk_pkg.sv =====
// ----------------------------------------------------------------------------
// tlk_pkg
// Shared types, constants and character helpers for the token lexer.
// ----------------------------------------------------------------------------
package tlk_pkg;

    localparam int MAX_TOKEN_LEN = 32;
    localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int ADDR_W        = $clog2(MAX_TOKEN_LEN);
    localparam int KW_COUNT      = 13;
    localparam int KW_IDX_W      = 4;
    localparam int KW_TEXT_W     = 64;

    localparam logic [2:0] KIND_ID       = 3'd0;
    localparam logic [2:0] KIND_KEYWORD  = 3'd1;
    localparam logic [2:0] KIND_NUMBER   = 3'd2;
    localparam logic [2:0] KIND_OPERATOR = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_RELOP,
        MODE_SLASH,
        MODE_BLOCK,
        MODE_BLOCK_STAR,
        MODE_LINE
    } mode_t;

    // keyword text, right-justified: last character in the low byte
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
        KW_TEXT_W'("if"), KW_TEXT_W'("else"), KW_TEXT_W'("for"),
        KW_TEXT_W'("while"), KW_TEXT_W'("do"), KW_TEXT_W'("int"),
        KW_TEXT_W'("read"), KW_TEXT_W'("write"), KW_TEXT_W'("switch"),
        KW_TEXT_W'("case"), KW_TEXT_W'("let"), KW_TEXT_W'("break"),
        KW_TEXT_W'("default")
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd2, 3'd4, 3'd3, 3'd5, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd4, 3'd3, 3'd5, 3'd7
    };

    typedef struct packed {
        logic [2:0]          kind;
        logic [KW_IDX_W-1:0] kw;
        logic [7:0]          ch;
        logic                last;
        logic                trunc;
        logic                err;
    } tok_t;

    typedef struct packed {
        logic             start;
        logic             step;
        logic [LEN_W-1:0] pos;
        logic [7:0]       ch;
    } kw_ctl_t;

    typedef struct packed {
        mode_t      mode;
        logic       emit;
        logic [2:0] kind;
        logic       append;
        logic       set_err;
    } scan_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_single_op(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "(" || c == ")" ||
               c == "{" || c == "}" || c == ";" || c == "," || c == ":";
    endfunction

    function automatic logic is_rel_op(input logic [7:0] c);
        return c == ">" || c == "<" || c == "=" || c == "!";
    endfunction

    function automatic logic kw_char_ok(input int k, input logic [LEN_W-1:0] pos,
                                        input logic [7:0] c);
        logic [2:0] sel;
        sel = KW_LEN[k] - 3'd1 - pos[2:0];
        if (pos >= LEN_W'(KW_LEN[k]))
            return 1'b0;
        return KW_TEXT[k][{sel, 3'b000} +: 8] == c;
    endfunction

    // first character of a token, scanned from idle
    function automatic scan_t scan_idle(input logic [7:0] c);
        scan_t r;
        r = '{mode: MODE_IDLE, emit: 1'b0, kind: KIND_OPERATOR, append: 1'b0, set_err: 1'b0};
        if (c == " " || c == 8'h09 || c == 8'h0a) begin
            r.mode = MODE_IDLE;
        end else if (is_letter(c)) begin
            r.mode   = MODE_IDENT;
            r.append = 1'b1;
        end else if (is_digit(c)) begin
            r.mode   = MODE_NUMBER;
            r.append = 1'b1;
        end else if (is_single_op(c)) begin
            r.emit = 1'b1;
        end else if (is_rel_op(c)) begin
            r.mode = MODE_RELOP;
        end else if (c == "/") begin
            r.mode = MODE_SLASH;
        end else begin
            r.emit    = 1'b1;
            r.kind    = KIND_ERROR;
            r.set_err = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== design/token_lexer_unit.sv =====
// ----------------------------------------------------------------------------
// token_lexer_unit
// Byte-serial lexical scanner: source bytes in, token characters out.
// ----------------------------------------------------------------------------
// Input stream: one source byte per item on s_axis_tdata; s_axis_tlast set
// flushes any pending token, clears the sticky error flag and returns to idle
// (the byte is then ignored).
// Output stream: one item per token character, kind in m_axis_tuser, the
// final character of each token marked by m_axis_tlast.
// Identifier and number characters are held in a 32-entry buffer RAM and
// replayed when the token ends: each is read from the RAM (registered read
// data) and then registered as output, one per cycle while the output is
// not stalled. Single-character results appear in the cycle after acceptance.
// Input is held off while an ended token's characters are replayed and,
// if the ending byte must be rescanned, while it is; also while the byte after
// a pending relational op or '/' is rescanned, and for the '=' of a pair.
// s_axis_tready is low outside the run state and whenever the output register
// is full and not being taken; a stalled receiver simply holds the current
// result and freezes the sequencer.
// Reset leaves the scanner idle with an empty buffer and error flag clear.
// ----------------------------------------------------------------------------
module token_lexer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [3:0] keyword_index, [11:4] token_char,
                                        // [12] truncated, [13] error_seen
    output logic [2:0]  m_axis_tuser,   // [2:0] token_kind
    output logic        m_axis_tlast    // last_of_token
);
    import tlk_pkg::*;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_REPLAY,
        ST_EQ,
        ST_SCAN
    } state_t;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic [7:0]          relop_reg, relop_next;
    logic                err_reg, err_next;
    logic [7:0]          pend_byte_reg, pend_byte_next;
    logic                pend_scan_reg, pend_scan_next;
    logic                pend_end_reg, pend_end_next;
    logic [2:0]          kind_reg, kind_next;
    logic [KW_IDX_W-1:0] kw_reg, kw_next;
    logic [LEN_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0]    emit_idx_reg, emit_idx_next;
    logic                dvalid_reg, dvalid_next;
    logic                out_valid_reg, out_valid_next;
    tok_t                out_reg, out_next;

    logic              out_free;
    logic              accept;
    logic [7:0]        cur_byte;
    scan_t             scan;
    logic              f_append, f_scan, f_replay, f_replay_scan, f_replay_end;
    logic              rd_go, emit_go;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_wa;
    logic [7:0]        ram_wd, ram_rd;
    kw_ctl_t           kw_ctl;
    logic              kw_hit;
    logic [KW_IDX_W-1:0] kw_index;

    tlk_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TOKEN_LEN)
    ) u_buf (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (ram_rd)
    );

    tlk_kw_match u_kw (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (kw_ctl),
        .len      (len_reg),
        .overflow (ovf_reg),
        .hit      (kw_hit),
        .index    (kw_index)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_RUN) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cur_byte      = (state_reg == ST_SCAN) ? pend_byte_reg : s_axis_tdata;
    assign scan          = scan_idle(cur_byte);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {2'b00, out_reg.err, out_reg.trunc, out_reg.ch, out_reg.kw};

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        relop_next     = relop_reg;
        err_next       = err_reg;
        pend_byte_next = pend_byte_reg;
        pend_scan_next = pend_scan_reg;
        pend_end_next  = pend_end_reg;
        kind_next      = kind_reg;
        kw_next        = kw_reg;
        rd_idx_next    = rd_idx_reg;
        emit_idx_next  = emit_idx_reg;
        dvalid_next    = dvalid_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        f_append       = 1'b0;
        f_scan         = 1'b0;
        f_replay       = 1'b0;
        f_replay_scan  = 1'b0;
        f_replay_end   = 1'b0;
        rd_go          = 1'b0;
        emit_go        = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_wa         = '0;
        ram_wd         = cur_byte;
        kw_ctl         = '{start: 1'b0, step: 1'b0, pos: len_reg, ch: cur_byte};

        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (s_axis_tlast)
                    begin
                        case (mode_reg) inside
                            MODE_IDENT, MODE_NUMBER:
                            begin
                                f_replay     = 1'b1;
                                f_replay_end = 1'b1;
                            end
                            MODE_RELOP, MODE_SLASH:
                            begin
                                out_valid_next = 1'b1;
                                out_next = '{kind: KIND_OPERATOR, kw: '0,
                                             ch: (mode_reg == MODE_RELOP) ? relop_reg : "/",
                                             last: 1'b1, trunc: 1'b0, err: err_reg};
                                mode_next  = MODE_IDLE;
                                relop_next = '0;
                                err_next   = 1'b0;
                            end
                            default:
                            begin
                                mode_next  = MODE_IDLE;
                                len_next   = '0;
                                ovf_next   = 1'b0;
                                relop_next = '0;
                                err_next   = 1'b0;
                            end
                        endcase
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_IDENT:
                            begin
                                if (is_letter(cur_byte) || is_digit(cur_byte))
                                    f_append = 1'b1;
                                else
                                begin
                                    f_replay      = 1'b1;
                                    f_replay_scan = 1'b1;
                                end
                            end
                            MODE_NUMBER:
                            begin
                                if (is_digit(cur_byte))
                                    f_append = 1'b1;
                                else
                                begin
                                    f_replay      = 1'b1;
                                    f_replay_scan = 1'b1;
                                end
                            end
                            MODE_RELOP:
                            begin
                                out_valid_next = 1'b1;
                                out_next = '{kind: KIND_OPERATOR, kw: '0, ch: relop_reg,
                                             last: (cur_byte != "="), trunc: 1'b0,
                                             err: err_reg};
                                mode_next      = MODE_IDLE;
                                relop_next     = '0;
                                pend_byte_next = cur_byte;
                                state_next     = (cur_byte == "=") ? ST_EQ : ST_SCAN;
                            end
                            MODE_SLASH:
                            begin
                                if (cur_byte == "*")
                                    mode_next = MODE_BLOCK;
                                else if (cur_byte == "/")
                                    mode_next = MODE_LINE;
                                else
                                begin
                                    out_valid_next = 1'b1;
                                    out_next = '{kind: KIND_OPERATOR, kw: '0, ch: "/",
                                                 last: 1'b1, trunc: 1'b0, err: err_reg};
                                    mode_next      = MODE_IDLE;
                                    pend_byte_next = cur_byte;
                                    state_next     = ST_SCAN;
                                end
                            end
                            MODE_BLOCK:
                            begin
                                if (cur_byte == "*")
                                    mode_next = MODE_BLOCK_STAR;
                            end
                            MODE_BLOCK_STAR:
                            begin
                                if (cur_byte == "/")
                                    mode_next = MODE_IDLE;
                                else if (cur_byte != "*")
                                    mode_next = MODE_BLOCK;
                            end
                            MODE_LINE:
                            begin
                                if (cur_byte == 8'h0a)
                                    mode_next = MODE_IDLE;
                            end
                            default:
                            begin
                                f_scan = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_REPLAY:
            begin
                rd_go   = (rd_idx_reg < len_reg) && (!dvalid_reg || out_free);
                emit_go = dvalid_reg && out_free;
                ram_re  = rd_go;
                if (rd_go)
                begin
                    rd_idx_next = rd_idx_reg + LEN_W'(1);
                    dvalid_next = 1'b1;
                end
                else if (emit_go)
                begin
                    dvalid_next = 1'b0;
                end
                if (emit_go)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{kind: kind_reg, kw: kw_reg, ch: ram_rd,
                                 last: (emit_idx_reg + LEN_W'(1) == len_reg),
                                 trunc: ovf_reg, err: err_reg};
                    emit_idx_next = emit_idx_reg + LEN_W'(1);
                    if (emit_idx_reg + LEN_W'(1) == len_reg)
                    begin
                        len_next   = '0;
                        ovf_next   = 1'b0;
                        mode_next  = MODE_IDLE;
                        relop_next = '0;
                        if (pend_end_reg)
                            err_next = 1'b0;
                        state_next = pend_scan_reg ? ST_SCAN : ST_RUN;
                    end
                end
            end
            ST_EQ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{kind: KIND_OPERATOR, kw: '0, ch: "=", last: 1'b1,
                                 trunc: 1'b0, err: err_reg};
                    state_next = ST_RUN;
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    f_scan     = 1'b1;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase

        // buffer write and keyword tracking never overlap a replay read
        if (f_append)
        begin
            if (len_reg < LEN_W'(MAX_TOKEN_LEN))
            begin
                ram_we      = 1'b1;
                ram_wa      = len_reg[ADDR_W-1:0];
                len_next    = len_reg + LEN_W'(1);
                kw_ctl.step = 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (f_scan)
        begin
            mode_next = scan.mode;
            len_next  = '0;
            ovf_next  = 1'b0;
            if (scan.mode == MODE_RELOP)
                relop_next = cur_byte;
            if (scan.append)
            begin
                ram_we       = 1'b1;
                ram_wa       = '0;
                len_next     = LEN_W'(1);
                kw_ctl.start = 1'b1;
            end
            if (scan.set_err)
                err_next = 1'b1;
            if (scan.emit)
            begin
                out_valid_next = 1'b1;
                out_next = '{kind: scan.kind, kw: '0, ch: cur_byte, last: 1'b1,
                             trunc: 1'b0, err: err_reg | scan.set_err};
            end
        end

        if (f_replay)
        begin
            state_next     = ST_REPLAY;
            rd_idx_next    = '0;
            emit_idx_next  = '0;
            dvalid_next    = 1'b0;
            pend_byte_next = cur_byte;
            pend_scan_next = f_replay_scan;
            pend_end_next  = f_replay_end;
            if (mode_reg == MODE_IDENT)
            begin
                kind_next = kw_hit ? KIND_KEYWORD : KIND_ID;
                kw_next   = kw_hit ? kw_index : '0;
            end
            else
            begin
                kind_next = KIND_NUMBER;
                kw_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            mode_reg      <= MODE_IDLE;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            relop_reg     <= '0;
            err_reg       <= 1'b0;
            pend_byte_reg <= '0;
            pend_scan_reg <= 1'b0;
            pend_end_reg  <= 1'b0;
            kind_reg      <= KIND_ID;
            kw_reg        <= '0;
            rd_idx_reg    <= '0;
            emit_idx_reg  <= '0;
            dvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            relop_reg     <= relop_next;
            err_reg       <= err_next;
            pend_byte_reg <= pend_byte_next;
            pend_scan_reg <= pend_scan_next;
            pend_end_reg  <= pend_end_next;
            kind_reg      <= kind_next;
            kw_reg        <= kw_next;
            rd_idx_reg    <= rd_idx_next;
            emit_idx_reg  <= emit_idx_next;
            dvalid_reg    <= dvalid_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

endmodule

// ===== design/tlk_ram.sv =====
// ----------------------------------------------------------------------------
// tlk_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tlk_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/tlk_kw_match.sv =====
// ----------------------------------------------------------------------------
// tlk_kw_match
// Keyword candidate tracker: narrows a candidate set as identifier characters
// are appended, and reports the matching keyword for the current length.
// ----------------------------------------------------------------------------
module tlk_kw_match (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tlk_pkg::kw_ctl_t              ctl,
    input  logic [tlk_pkg::LEN_W-1:0]     len,
    input  logic                          overflow,
    output logic                          hit,
    output logic [tlk_pkg::KW_IDX_W-1:0]  index
);
    import tlk_pkg::*;

    logic [KW_COUNT-1:0] cand_reg;
    logic [KW_COUNT-1:0] cand_next;

    always_comb
    begin
        cand_next = cand_reg;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (ctl.start)
            begin
                cand_next[k] = kw_char_ok(k, '0, ctl.ch);
            end
            else if (ctl.step)
            begin
                cand_next[k] = cand_reg[k] & kw_char_ok(k, ctl.pos, ctl.ch);
            end
        end
    end

    always_comb
    begin
        hit   = 1'b0;
        index = '0;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && !overflow && len == LEN_W'(KW_LEN[k]))
            begin
                hit   = 1'b1;
                index = KW_IDX_W'(k);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

endmodule
